// ----- hw/rtl/msp_pkg.sv -----
`timescale 1ns / 1ps

package msp_pkg;

   localparam int NUM_CHANNELS = 12;
   localparam int FRAME_DIGITS = 2 * NUM_CHANNELS + 2;
   localparam int DIGIT_W      = $clog2(FRAME_DIGITS + 1);

   localparam logic [7:0] POS_RESET = 8'hb8;
   localparam logic [7:0] SYNC_CHAR = 8'h3a;

   localparam logic [7:0]  SLOT_TICKS_RESET  = 8'd19;
   localparam logic [7:0]  PULSE_SLOTS_RESET = 8'd241;
   localparam logic [15:0] GAP_TICKS_RESET   = 16'd35100;

   localparam logic [1:0] CSR_SLOT_TICKS  = 2'd0;
   localparam logic [1:0] CSR_PULSE_SLOTS = 2'd1;
   localparam logic [1:0] CSR_GAP_TICKS   = 2'd2;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
   localparam logic [1:0] STATUS_BAD_HEX  = 2'd2;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd3;

   typedef logic [NUM_CHANNELS-1:0][7:0] pos_array_type;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0] servo_lines;
      logic                    in_pulse;
      logic [1:0]              frame_status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  slot_ticks;
      logic [7:0]  pulse_slots;
      logic [15:0] gap_ticks;
   } timing_cfg_type;

   typedef struct packed {
      logic          valid;
      pos_array_type positions;
   } pend_type;

   // Returns {valid, nibble}; a non-hex character gives valid low and nibble zero.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/msp_rx.sv -----
`timescale 1ns / 1ps

module msp_rx (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_go,
   input  logic [7:0]          rx_byte,
   input  logic                take,
   output msp_pkg::pend_type   pend,
   output logic [1:0]          status
);
   import msp_pkg::*;

   pos_array_type      frame_bytes_ff, frame_bytes_in;
   pos_array_type      pend_pos_ff, pend_pos_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [7:0]         sum_ff, sum_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               wait_ff, wait_in;
   logic               hex_err_ff, hex_err_in;
   logic [3:0]         hi_nib_ff, hi_nib_in;
   logic [4:0]         dec;
   logic [DIGIT_W-2:0] byte_idx;

   always_comb begin
      frame_bytes_in = frame_bytes_ff;
      pend_pos_in    = pend_pos_ff;
      pend_valid_in  = pend_valid_ff;
      sum_in         = sum_ff;
      digit_in       = digit_ff;
      wait_in        = wait_ff;
      hex_err_in     = hex_err_ff;
      hi_nib_in      = hi_nib_ff;
      status         = STATUS_NONE;
      dec            = hex_decode(rx_byte);
      byte_idx       = digit_ff[DIGIT_W-1:1];
      if (take) begin
         pend_valid_in = 1'b0;
      end
      if (byte_go) begin
         if (wait_ff) begin
            if (rx_byte == SYNC_CHAR) begin
               wait_in    = 1'b0;
               digit_in   = '0;
               sum_in     = 8'd0;
               hex_err_in = 1'b0;
            end
         end else begin
            hex_err_in = hex_err_ff | ~dec[4];
            if (!digit_ff[0]) begin
               sum_in    = sum_ff + {dec[3:0], 4'd0};
               hi_nib_in = dec[3:0];
            end else begin
               sum_in = sum_ff + {4'd0, dec[3:0]};
               for (int k = 0; k < NUM_CHANNELS; k++) begin
                  if (byte_idx == (DIGIT_W-1)'(k)) begin
                     frame_bytes_in[k] = {hi_nib_ff, dec[3:0]};
                  end
               end
            end
            digit_in = digit_ff + 1'b1;
            if (digit_in == DIGIT_W'(FRAME_DIGITS)) begin
               wait_in = 1'b1;
               if (hex_err_in) begin
                  status = STATUS_BAD_HEX;
               end else if (sum_in != 8'd0) begin
                  status = STATUS_CHECKSUM;
               end else begin
                  status        = STATUS_ACCEPTED;
                  pend_pos_in   = frame_bytes_ff;
                  pend_valid_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_bytes_ff <= frame_bytes_in;
      pend_pos_ff    <= pend_pos_in;
      hi_nib_ff      <= hi_nib_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         sum_ff        <= 8'd0;
         digit_ff      <= '0;
         wait_ff       <= 1'b0;
         hex_err_ff    <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         sum_ff        <= sum_in;
         digit_ff      <= digit_in;
         wait_ff       <= wait_in;
         hex_err_ff    <= hex_err_in;
      end
   end

   assign pend.valid     = pend_valid_ff;
   assign pend.positions = pend_pos_ff;

endmodule

// ----- hw/rtl/msp_pwm.sv -----
`timescale 1ns / 1ps

module msp_pwm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              tick,
   input  msp_pkg::timing_cfg_type           cfg,
   input  msp_pkg::pend_type                 pend,
   output logic                              take,
   output logic [msp_pkg::NUM_CHANNELS-1:0]  lines_in,
   output logic                              in_pulse
);
   import msp_pkg::*;

   pos_array_type           pos_ff, pos_in;
   logic [NUM_CHANNELS-1:0] lines_ff;
   logic [7:0]              slot_ff, slot_in;
   logic [15:0]             count_ff, count_in;
   logic                    gap_ff, gap_in;
   logic [16:0]             count_next;
   logic [8:0]              slot_next;

   always_comb begin
      pos_in     = pos_ff;
      lines_in   = lines_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      gap_in     = gap_ff;
      take       = 1'b0;
      count_next = {1'b0, count_ff} + 17'd1;
      slot_next  = {1'b0, slot_ff} + 9'd1;
      if (tick) begin
         if (gap_ff) begin
            if (count_next >= {1'b0, cfg.gap_ticks}) begin
               count_in = 16'd0;
               gap_in   = 1'b0;
            end else begin
               count_in = count_next[15:0];
            end
         end else begin
            if (count_ff == 16'd0) begin
               if (slot_ff == 8'd0) begin
                  if (pend.valid) begin
                     pos_in = pend.positions;
                     take   = 1'b1;
                  end
                  lines_in = '1;
               end
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (slot_ff > pos_in[i]) begin
                     lines_in[i] = 1'b0;
                  end
               end
            end
            if (count_next >= {9'd0, cfg.slot_ticks}) begin
               count_in = 16'd0;
               if (slot_next >= {1'b0, cfg.pulse_slots}) begin
                  slot_in = 8'd0;
                  gap_in  = 1'b1;
               end else begin
                  slot_in = slot_next[7:0];
               end
            end else begin
               count_in = count_next[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_in_reset: for (int i = 0; i < NUM_CHANNELS; i++) begin
            pos_ff[i] <= POS_RESET;
         end
         lines_ff <= '0;
         slot_ff  <= 8'd0;
         count_ff <= 16'd0;
         gap_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         lines_ff <= lines_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         gap_ff   <= gap_in;
      end
   end

   assign in_pulse = ~gap_ff;

endmodule

// ----- hw/rtl/multi_servo_pwm_with_hex_frame_rx_unit.sv -----
`timescale 1ns / 1ps

// Twelve-channel servo pulse generator with a hex frame receiver. Each request is either a
// timer tick or a received serial byte, and each request yields exactly one response with
// the servo line levels after it, the phase the request fell in, and a frame status that is
// nonzero only on the byte that completes a frame. A request is registered on entry and its
// response is formed into an output register when it advances; one request is taken every
// cycle while the response side keeps up, and a stalled response holds back at most one more
// request in the input register. The user must write timing registers through the csr port
// only while the block is idle, unenforced by the block; writes take effect on the following ticks.

module multi_servo_pwm_with_hex_frame_rx_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msp_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import msp_pkg::*;

   timing_cfg_type          cfg_ff, cfg_in;
   logic                    in_valid_ff, in_valid_in;
   req_type                 in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_data_ff;
   logic                    advance;
   logic                    req_take;
   logic                    take;
   pend_type                pend;
   logic [1:0]              status;
   logic [NUM_CHANNELS-1:0] lines_in;
   logic                    in_pulse;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SLOT_TICKS:  cfg_in.slot_ticks  = csr_wdata[7:0];
            CSR_PULSE_SLOTS: cfg_in.pulse_slots = csr_wdata[7:0];
            CSR_GAP_TICKS:   cfg_in.gap_ticks   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
      in_valid_in = req_take | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & rsp_stall);
   end

   msp_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .byte_go (advance & (in_data_ff.func == FUNC_BYTE)),
      .rx_byte (in_data_ff.rx_byte),
      .take    (take),
      .pend    (pend),
      .status  (status)
   );

   msp_pwm u_pwm (
      .clock    (clock),
      .reset    (reset),
      .tick     (advance & (in_data_ff.func == FUNC_TICK)),
      .cfg      (cfg_ff),
      .pend     (pend),
      .take     (take),
      .lines_in (lines_in),
      .in_pulse (in_pulse)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff.servo_lines  <= lines_in;
         out_data_ff.in_pulse     <= in_pulse;
         out_data_ff.frame_status <= status;
      end
      if (reset) begin
         cfg_ff.slot_ticks  <= SLOT_TICKS_RESET;
         cfg_ff.pulse_slots <= PULSE_SLOTS_RESET;
         cfg_ff.gap_ticks   <= GAP_TICKS_RESET;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- hw/rtl/msp_checker.sv -----
`timescale 1ns / 1ps

module msp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input msp_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input msp_pkg::rsp_type  rsp_data
);
   import msp_pkg::*;

   // A stalled response stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Requests are held back only while the response side is backed up.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response backpressure");

   // A response rising from an empty output was a request taken into the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response without a matching request");

   // A tick request that enters an empty block never reports a frame status.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.func == FUNC_TICK && !rsp_valid &&
      !$past(req_valid && !req_stall) |=> ##1
      (!rsp_valid || rsp_data.frame_status == STATUS_NONE))
      else $error("frame status reported for a tick");

endmodule

bind multi_servo_pwm_with_hex_frame_rx_unit msp_checker u_msp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
